@@ hdl/ibusrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ibusrc_pkg
// Shared types and constants for the iBUS RC frame receiver.
// ----------------------------------------------------------------------------
package ibusrc_pkg;

   localparam int CHANNEL_COUNT_DEF = 14;
   localparam int NUM_BANKS         = 2;
   localparam int BANK_W            = $clog2(NUM_BANKS);
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [23:0] TIMEOUT_RESET = 24'd100000;
   localparam logic [7:0]  FRAME_START   = 8'h20;
   localparam logic [4:0]  FRAME_LAST    = 5'd31;
   localparam logic [4:0]  FIRST_DATA    = 5'd2;
   localparam logic [4:0]  LAST_DATA     = 5'd29;
   localparam logic [4:0]  FIRST_HIGH    = 5'd3;
   localparam logic [15:0] CSUM_INIT     = 16'hFFFF;
   localparam logic [24:0] IDLE_MAX      = 25'h1FFFFFF;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef enum logic [1:0] {
      ST_DATA    = 2'd0,
      ST_CSUM    = 2'd1,
      ST_TIMEOUT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CMD_FRAME    = 2'd0,
      CMD_CSUM_ERR = 2'd1,
      CMD_TIMEOUT  = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [BANK_W-1:0] bank;
   } cmd_type;

   typedef struct packed {
      logic              valid;
      logic [BANK_W-1:0] bank;
   } release_type;

endpackage

@@ hdl/ibusrc_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// ibusrc_cmd_fifo
// Short command queue between the frame front end and the result sequencer.
// ----------------------------------------------------------------------------
module ibusrc_cmd_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ibusrc_pkg::cmd_type push_cmd,
   output logic               full,
   input  logic               pop,
   output ibusrc_pkg::cmd_type pop_cmd,
   output logic               empty
);
   import ibusrc_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type            mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ hdl/ibusrc_front.sv @@
// ----------------------------------------------------------------------------
// ibusrc_front
// Accepts bytes and ticks, tracks frame position, checksum and idle time,
// fills the channel banks and queues frame-end and timeout commands.
// ----------------------------------------------------------------------------
module ibusrc_front #(
   parameter int CHANNEL_COUNT = ibusrc_pkg::CHANNEL_COUNT_DEF,
   parameter int IDX_W         = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          csr_wr_en,
   input  logic [23:0]                   csr_wr_data,
   output logic                          push,
   output ibusrc_pkg::cmd_type           push_cmd,
   input  logic                          q_full,
   input  ibusrc_pkg::release_type       bank_release,
   input  logic [ibusrc_pkg::BANK_W-1:0] rd_bank,
   input  logic [IDX_W-1:0]              rd_idx,
   output logic [15:0]                   rd_data
);
   import ibusrc_pkg::*;

   logic [23:0]          limit_ff;
   logic                 in_frame_ff, in_frame_in;
   logic [4:0]           pos_ff, pos_in;
   logic [15:0]          csum_ff, csum_in;
   logic [7:0]           low_ff, low_in;
   logic [24:0]          idle_ff, idle_in;
   logic                 tor_ff, tor_in;
   logic [BANK_W-1:0]    wb_ff, wb_in;
   logic [NUM_BANKS-1:0] busy_ff, busy_in;
   logic [15:0]          store_ff [NUM_BANKS][CHANNEL_COUNT];

   logic                 accept;
   logic [4:0]           pos_next;
   logic [4:0]           ch;
   logic [15:0]          csum_final;
   logic                 wr_en;

   // hold everything while the queue is full or the bank being filled is
   // still being played out
   assign req_stall = q_full | busy_ff[wb_ff];
   assign accept    = req_valid & ~req_stall;
   assign pos_next  = pos_ff + 5'd1;
   assign ch        = (pos_next - FIRST_HIGH) >> 1;
   assign csum_final = csum_ff - {req_rx_byte, 8'h00};
   assign rd_data   = store_ff[rd_bank][rd_idx];

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      csum_in     = csum_ff;
      low_in      = low_ff;
      idle_in     = idle_ff;
      tor_in      = tor_ff;
      wb_in       = wb_ff;
      busy_in     = busy_ff;
      push        = 1'b0;
      push_cmd    = '{kind: CMD_TIMEOUT, bank: wb_ff};
      wr_en       = 1'b0;

      if (bank_release.valid) begin
         busy_in[bank_release.bank] = 1'b0;
      end

      if (accept) begin
         if (req_opcode == OP_TICK) begin
            if (idle_ff != IDLE_MAX) begin
               idle_in = idle_ff + 25'd1;
            end
            if ((idle_in > {1'b0, limit_ff}) && !tor_ff) begin
               tor_in   = 1'b1;
               push     = 1'b1;
               push_cmd = '{kind: CMD_TIMEOUT, bank: wb_ff};
            end
         end else begin
            idle_in = '0;
            tor_in  = 1'b0;
            if (!in_frame_ff) begin
               if (req_rx_byte == FRAME_START) begin
                  in_frame_in = 1'b1;
                  pos_in      = '0;
                  csum_in     = CSUM_INIT - {8'h00, req_rx_byte};
               end
            end else if (pos_next != FRAME_LAST) begin
               pos_in  = pos_next;
               csum_in = csum_ff - {8'h00, req_rx_byte};
               if (pos_next >= FIRST_DATA && pos_next <= LAST_DATA) begin
                  if (!pos_next[0]) begin
                     low_in = req_rx_byte;
                  end else if (ch < 5'(CHANNEL_COUNT)) begin
                     wr_en = 1'b1;
                  end
               end
            end else begin
               in_frame_in = 1'b0;
               pos_in      = '0;
               csum_in     = CSUM_INIT;
               push        = 1'b1;
               if (csum_final != 16'h0000) begin
                  push_cmd = '{kind: CMD_CSUM_ERR, bank: wb_ff};
               end else begin
                  push_cmd       = '{kind: CMD_FRAME, bank: wb_ff};
                  busy_in[wb_ff] = 1'b1;
                  wb_in          = (wb_ff == BANK_W'(NUM_BANKS - 1)) ? '0 : wb_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= TIMEOUT_RESET;
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         csum_ff     <= CSUM_INIT;
         low_ff      <= '0;
         idle_ff     <= '0;
         tor_ff      <= 1'b0;
         wb_ff       <= '0;
         busy_ff     <= '0;
      end else begin
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         csum_ff     <= csum_in;
         low_ff      <= low_in;
         idle_ff     <= idle_in;
         tor_ff      <= tor_in;
         wb_ff       <= wb_in;
         busy_ff     <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wb_ff][ch[IDX_W-1:0]] <= {req_rx_byte, low_ff};
      end
   end

endmodule

@@ hdl/ibusrc_back.sv @@
// ----------------------------------------------------------------------------
// ibusrc_back
// Pops queued commands and plays out results: one error or timeout result,
// or a good frame's channels from its bank, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module ibusrc_back #(
   parameter int CHANNEL_COUNT = ibusrc_pkg::CHANNEL_COUNT_DEF,
   parameter int IDX_W         = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_empty,
   input  ibusrc_pkg::cmd_type           q_cmd,
   output logic                          pop,
   output ibusrc_pkg::release_type       bank_release,
   output logic [ibusrc_pkg::BANK_W-1:0] rd_bank,
   output logic [IDX_W-1:0]              rd_idx,
   input  logic [15:0]                   rd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [3:0]                    rsp_channel_index,
   output logic [15:0]                   rsp_channel_value,
   output logic                          rsp_last
);
   import ibusrc_pkg::*;

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_EMIT = 2'b10
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [3:0]        cnt_ff, cnt_in;
   logic [BANK_W-1:0] bank_ff, bank_in;
   logic              vld_ff, vld_in;
   status_type        status_ff, status_in;
   logic [3:0]        idx_ff, idx_in;
   logic [15:0]       value_ff, value_in;
   logic              last_ff, last_in;
   logic              out_free;
   logic              final_ch;

   assign out_free = ~vld_ff | ~rsp_stall;
   assign final_ch = (cnt_ff == 4'(CHANNEL_COUNT - 1));
   assign rd_bank  = bank_ff;
   assign rd_idx   = cnt_ff[IDX_W-1:0];

   assign rsp_valid         = vld_ff;
   assign rsp_status        = status_ff;
   assign rsp_channel_index = idx_ff;
   assign rsp_channel_value = value_ff;
   assign rsp_last          = last_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      bank_in      = bank_ff;
      vld_in       = vld_ff & rsp_stall;
      status_in    = status_ff;
      idx_in       = idx_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      pop          = 1'b0;
      bank_release = '{valid: 1'b0, bank: bank_ff};

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty && out_free) begin
               pop = 1'b1;
               unique case (q_cmd.kind)
                  CMD_FRAME: begin
                     state_in = B_EMIT;
                     cnt_in   = '0;
                     bank_in  = q_cmd.bank;
                  end
                  CMD_CSUM_ERR: begin
                     vld_in    = 1'b1;
                     status_in = ST_CSUM;
                     idx_in    = '0;
                     value_in  = '0;
                     last_in   = 1'b1;
                  end
                  default: begin
                     vld_in    = 1'b1;
                     status_in = ST_TIMEOUT;
                     idx_in    = '0;
                     value_in  = '0;
                     last_in   = 1'b1;
                  end
               endcase
            end
         end
         B_EMIT: begin
            if (out_free) begin
               vld_in    = 1'b1;
               status_in = ST_DATA;
               idx_in    = cnt_ff;
               value_in  = rd_data;
               last_in   = final_ch;
               if (final_ch) begin
                  state_in     = B_IDLE;
                  bank_release = '{valid: 1'b1, bank: bank_ff};
               end else begin
                  cnt_in = cnt_ff + 4'd1;
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         cnt_ff   <= '0;
         bank_ff  <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         bank_ff  <= bank_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      idx_ff    <= idx_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

endmodule

@@ hdl/ibus_rc_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// ibus_rc_frame_receiver
// iBUS RC frame decoder: UART bytes and microsecond ticks in, channel data,
// checksum errors and link timeouts out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one transaction per received byte (opcode 0) or 1 us tick
//            (opcode 1). A byte 0x20 while idle opens a 32-byte frame.
//   rsp_*  : result transactions. A good frame gives CHANNEL_COUNT channel
//            results with last on the final one; a bad checksum or a link
//            timeout gives a single result with last set.
//   csr_*  : timeout_limit write, taken whenever csr_wr_en is high.
// Flow: a taken request that ends a frame or times out writes a command into
//   the queue; the back end pops it into an error or timeout result in the
//   output register, or into state B_EMIT for a good frame. Channels then
//   follow at one per cycle unless rsp_stall holds them, limited by the
//   single output register fed from the channel bank read.
// A two-entry command queue and two channel banks sit between front and
//   back; req_stall rises only when the queue is full or both banks hold
//   frames not yet played out, so a stalled rsp side backs up into req.
// Reset clears frame, checksum, idle and queue state; timeout_limit returns
//   to 100000.
// ----------------------------------------------------------------------------
module ibus_rc_frame_receiver #(
   parameter int CHANNEL_COUNT = ibusrc_pkg::CHANNEL_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_channel_index,
   output logic [15:0] rsp_channel_value,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data
);
   import ibusrc_pkg::*;

   localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

   logic              push;
   cmd_type           push_cmd;
   logic              q_full;
   logic              q_empty;
   logic              pop;
   cmd_type           q_cmd;
   release_type       bank_release;
   logic [BANK_W-1:0] rd_bank;
   logic [IDX_W-1:0]  rd_idx;
   logic [15:0]       rd_data;

   ibusrc_front #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .IDX_W         (IDX_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_rx_byte  (req_rx_byte),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .push         (push),
      .push_cmd     (push_cmd),
      .q_full       (q_full),
      .bank_release (bank_release),
      .rd_bank      (rd_bank),
      .rd_idx       (rd_idx),
      .rd_data      (rd_data)
   );

   ibusrc_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .pop_cmd  (q_cmd),
      .empty    (q_empty)
   );

   ibusrc_back #(
      .CHANNEL_COUNT (CHANNEL_COUNT),
      .IDX_W         (IDX_W)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_cmd             (q_cmd),
      .pop               (pop),
      .bank_release      (bank_release),
      .rd_bank           (rd_bank),
      .rd_idx            (rd_idx),
      .rd_data           (rd_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last          (rsp_last)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("command pushed into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("command popped from empty queue");

   a_release_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (bank_release.valid && push && push_cmd.kind == CMD_FRAME)
      |-> (bank_release.bank != push_cmd.bank))
      else $error("bank released and claimed in the same cycle");

   a_status_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_DATA) |-> (rsp_last && rsp_channel_index == 4'd0))
      else $error("error or timeout result with bad index or last");

endmodule

@@ test/ibus_rc_frame_receiver_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibus_rc_frame_receiver_tb
// Self-checking bench for the iBUS RC frame receiver. Byte and tick
// transactions go in under random gaps and result stalls; a built-in decoder
// model predicts channel, checksum-error and link-timeout results, and every
// result is matched in order. Runs several timeout_limit settings and one
// long result hold-off that backs the block up into its request side.
// ----------------------------------------------------------------------------
module ibus_rc_frame_receiver_tb;
   import ibusrc_pkg::*;

   localparam int NUM_CH      = CHANNEL_COUNT_DEF;
   localparam int SETTLE      = 24;
   localparam int CYCLE_LIMIT = 200000;

   typedef logic [7:0]  frame_bytes_type [32];
   typedef logic [15:0] chan_set_type [NUM_CH];

   typedef struct packed {
      status_type  status;
      logic [3:0]  idx;
      logic [15:0] val;
      logic        last;
   } rc_result_type;

   // decoder model plus the queue of results it expects
   class ibus_decode_board_type;
      logic [23:0] limit = TIMEOUT_RESET;
      bit          in_frame;
      logic [4:0]  pos = '0;
      logic [15:0] csum = CSUM_INIT;
      logic [7:0]  low_hold = '0;
      logic [15:0] store [NUM_CH];
      logic [24:0] idle = '0;
      bit          to_reported;
      rc_result_type pending_results[$];
      int unsigned useful, made, checked, faults;
      int unsigned good_frames, bad_frames, timeouts, inputs;

      function void flag(string msg);
         faults++;
         if (faults <= 10) $display("mismatch: %s", msg);
      endfunction

      function void expect_result(status_type s, logic [3:0] i, logic [15:0] v, logic l);
         rc_result_type r;
         r.status = s;
         r.idx    = i;
         r.val    = v;
         r.last   = l;
         pending_results.push_back(r);
         made++;
      endfunction

      function void take_input(logic op, logic [7:0] b);
         logic [4:0] ch;
         inputs++;
         if (op == OP_TICK) begin
            if (idle != IDLE_MAX) idle++;
            if (idle > {1'b0, limit} && !to_reported) begin
               to_reported = 1;
               timeouts++;
               useful++;
               expect_result(ST_TIMEOUT, 4'd0, 16'd0, 1'b1);
            end
            return;
         end
         idle        = '0;
         to_reported = 0;
         if (!in_frame) begin
            if (b == FRAME_START) begin
               in_frame = 1;
               pos      = '0;
               csum     = CSUM_INIT - {8'h00, b};
               useful++;
            end
            return;
         end
         useful++;
         pos = pos + 5'd1;
         if (pos < FRAME_LAST) begin
            csum = csum - {8'h00, b};
            if (pos >= FIRST_DATA && pos <= LAST_DATA) begin
               if (!pos[0]) begin
                  low_hold = b;
               end else begin
                  ch = (pos - FIRST_HIGH) >> 1;
                  if (ch < NUM_CH) store[ch] = {b, low_hold};
               end
            end
            return;
         end
         // closing byte carries the checksum high byte
         csum     = csum - {b, 8'h00};
         in_frame = 0;
         pos      = '0;
         if (csum != 16'd0) begin
            bad_frames++;
            expect_result(ST_CSUM, 4'd0, 16'd0, 1'b1);
         end else begin
            good_frames++;
            for (int n = 0; n < NUM_CH; n++)
               expect_result(ST_DATA, n[3:0], store[n], n == NUM_CH - 1);
         end
         csum = CSUM_INIT;
      endfunction

      function void match_result(logic [1:0] s, logic [3:0] i, logic [15:0] v, logic l);
         rc_result_type e;
         checked++;
         if (pending_results.size() == 0) begin
            flag($sformatf("unexpected result status=%0d idx=%0d val=%h last=%0d",
                           s, i, v, l));
            return;
         end
         e = pending_results.pop_front();
         if (s !== e.status || i !== e.idx || v !== e.val || l !== e.last)
            flag($sformatf("exp status=%0d idx=%0d val=%h last=%0d, got %0d %0d %h %0d",
                           e.status, e.idx, e.val, e.last, s, i, v, l));
      endfunction

      function int unsigned outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_opcode  = OP_BYTE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_stall   = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic [23:0] csr_wr_data = '0;
   logic        req_stall;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_channel_index;
   logic [15:0] rsp_channel_value;
   logic        rsp_last;

   ibus_decode_board_type board = new();
   bit          send_idle = 1;
   bit          recv_idle = 1;
   int unsigned hold_cycles = 0;
   int unsigned cycle_count = 0;

   ibus_rc_frame_receiver u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, board.outstanding());
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.match_result(rsp_status, rsp_channel_index, rsp_channel_value, rsp_last);
   end

   // result side: random stall before each transaction, or one long hold-off
   initial begin : rsp_side
      int unsigned hold;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            hold        = hold_cycles;
            hold_cycles = 0;
         end else begin
            hold = recv_idle ? $urandom_range(0, 5) : 0;
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   task automatic send_item(input logic op, input logic [7:0] b);
      int unsigned gap;
      gap = send_idle ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_input(op, b);
   endtask

   task automatic send_ticks(input int unsigned n);
      repeat (n) send_item(OP_TICK, 8'($urandom));
   endtask

   task automatic send_frame(input frame_bytes_type f, input int lo, input int hi);
      for (int i = lo; i <= hi; i++) send_item(OP_BYTE, f[i]);
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 5))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic void fill_values(output chan_set_type v);
      for (int i = 0; i < NUM_CH; i++) v[i] = pick_value();
   endfunction

   function automatic void make_frame(output frame_bytes_type f, input chan_set_type v,
                                      input bit good);
      logic [15:0] acc;
      f[0] = FRAME_START;
      f[1] = 8'($urandom);
      for (int i = 0; i < NUM_CH; i++) begin
         f[2 + 2 * i] = v[i][7:0];
         f[3 + 2 * i] = v[i][15:8];
      end
      acc = CSUM_INIT;
      for (int i = 0; i < 30; i++) acc = acc - {8'h00, f[i]};
      // byte 30 zeroes the low half, byte 31 takes the high half
      f[30] = acc[7:0];
      acc   = acc - {8'h00, f[30]};
      f[31] = acc[15:8];
      if (!good) begin
         if ($urandom_range(0, 1)) f[30] = f[30] ^ 8'($urandom_range(1, 255));
         else                      f[31] = f[31] ^ 8'($urandom_range(1, 255));
      end
   endfunction

   task automatic settle();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_limit(input logic [23:0] v);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.limit = v;
   endtask

   // random sequences, mostly well-formed frames
   task automatic run_mix(input int unsigned quota, input int unsigned min_results);
      int unsigned     start;
      int unsigned     r;
      logic [7:0]      b;
      frame_bytes_type f;
      chan_set_type    v;
      start = board.useful;
      while (board.useful - start < quota || board.made < min_results) begin
         r = $urandom_range(0, 99);
         fill_values(v);
         if (r < 45) begin
            make_frame(f, v, 1);
            send_frame(f, 0, 31);
         end else if (r < 60) begin
            make_frame(f, v, 0);
            send_frame(f, 0, 31);
         end else if (r < 70) begin
            repeat ($urandom_range(1, 4)) begin
               b = 8'($urandom);
               if (b == FRAME_START) b = b ^ 8'h01;
               send_item(OP_BYTE, b);
            end
         end else if (r < 85) begin
            send_ticks($urandom_range(1, 30));
         end else begin
            // cut-off frame, then idle time
            make_frame(f, v, 1);
            send_frame(f, 0, $urandom_range(0, 30));
            send_ticks($urandom_range(1, 30));
         end
      end
   endtask

   initial begin
      frame_bytes_type f;
      chan_set_type    v;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // stray bytes, short idle, then one good frame with edge values
      send_item(OP_BYTE, 8'h00);
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, 8'h21);
      send_ticks(3);
      fill_values(v);
      v[0]          = 16'h0000;
      v[1]          = 16'hFFFF;
      v[2]          = 16'h2020;
      v[NUM_CH - 1] = 16'hFFFF;
      make_frame(f, v, 1);
      send_frame(f, 0, 31);

      // zero limit: every first tick after a byte times out; a bad frame
      // is split by idle time
      set_limit(24'd0);
      send_ticks(2);
      fill_values(v);
      make_frame(f, v, 0);
      send_frame(f, 0, 9);
      send_ticks(2);
      send_frame(f, 10, 31);
      send_item(OP_BYTE, 8'h5A);
      send_ticks(1);

      // widest limit, back-to-back on both sides, long result hold-off
      // while frames keep streaming in
      set_limit(24'hFFFFFF);
      send_idle   = 0;
      recv_idle   = 0;
      hold_cycles = 400;
      repeat (2) begin
         fill_values(v);
         make_frame(f, v, 1);
         send_frame(f, 0, 31);
      end
      send_ticks(4);
      send_idle = 1;
      recv_idle = 1;

      set_limit(24'($urandom_range(1, 25)));
      run_mix(1, 0);

      settle();
      if (board.outstanding() != 0)
         board.flag($sformatf("%0d expected results never arrived", board.outstanding()));
      $display("run: %0d transactions in, %0d results checked in %0d cycles",
               board.inputs, board.checked, cycle_count);
      $display("run: %0d good frames, %0d checksum errors, %0d link timeouts, %0d mismatches",
               board.good_frames, board.bad_frames, board.timeouts, board.faults);
      if (board.faults == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
